### src/bdsu_pkg.sv
// Shared types, constants and the pixel doubling function of the bitmap 2x upscaler.
// Depends on nothing; every other file of the block refers to it by scoped names.
package bdsu_pkg;

   localparam int unsigned MAX_ROW_BYTES_DEF = 16;

   localparam int unsigned ROW_BYTES_W = 5;
   localparam int unsigned ROW_COUNT_W = 10;
   localparam int unsigned CSR_DATA_W  = 10;

   localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST = 5'd1;
   localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RST = 10'd1;

   typedef enum logic [0:0] {
      CSR_ROW_BYTES = 1'b0,
      CSR_ROW_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOW,
      ST_REPLAY_HI,
      ST_REPLAY_LO
   } state_type;

   typedef struct packed {
      logic take;
      logic emit_low;
      logic emit_rhi;
      logic emit_rlo;
   } cmd_type;

   typedef struct packed {
      logic load_ok;
      logic row_end;
      logic replay_last;
   } status_type;

   // Spread each bit into a pair: abcdefgh -> aabbccddeeffgghh.
   function automatic logic [15:0] double_bits(input logic [7:0] v);
      logic [15:0] t;
      t = ({8'd0, v & 8'hF0} << 4) | {8'd0, v & 8'h0F};
      t = ((t << 2) | t) & 16'h3333;
      t = ((t << 1) | t) & 16'h5555;
      return t | (t << 1);
   endfunction

endpackage

### src/bitmap_double_size_upscaler.sv
// Top level of the one-bit-per-pixel bitmap 2x nearest-neighbor upscaler.
// Depends on bdsu_pkg, bdsu_ctrl and bdsu_dp; holds the two configuration registers.
//
// Usage:
//   Send source bytes on req_ (pixel_byte, leftmost pixel in the MSB), row by row.
//   Each request yields two rsp_ bytes: the high then the low half of the doubled byte.
//   After the last byte of a source row the whole doubled row is replayed from the
//   line store, so each row appears twice. rsp_row_last marks the last byte of each
//   output row; rsp_image_last marks only the final replayed byte of the last row.
//   Program row_bytes (index 0) and row_count (index 1) through csr_ while idle.
// Output flow:
//   The first output byte is valid in the cycle after the request is taken. One output
//   byte leaves per cycle while rsp_ready is high, paced by the single output register;
//   a source byte yields two output bytes, plus two more per byte in its row's replay.
//   The next request is taken once the previous one and any replay are out.
// Reset:
//   Synchronous, active high. Counters return to row 0, column 0, the output register
//   empties and the registers read row_bytes = 1, row_count = 1.
// Stall:
//   While rsp_ready is low the output register holds its byte and the sequencer waits.
module bitmap_double_size_upscaler #(
   parameter int unsigned MAX_ROW_BYTES = bdsu_pkg::MAX_ROW_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_pixel_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_row_last,
   output logic                               rsp_image_last,
   input  logic                               csr_we,
   input  logic [0:0]                         csr_index,
   input  logic [bdsu_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [bdsu_pkg::ROW_BYTES_W-1:0] row_bytes_ff;
   logic [bdsu_pkg::ROW_COUNT_W-1:0] row_count_ff;

   bdsu_pkg::cmd_type    cmd;
   bdsu_pkg::status_type status;

   // Configuration writes: take the low bits of the data for each register.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff <= bdsu_pkg::ROW_BYTES_RST;
         row_count_ff <= bdsu_pkg::ROW_COUNT_RST;
      end else if (csr_we) begin
         case (bdsu_pkg::csr_index_type'(csr_index))
            bdsu_pkg::CSR_ROW_BYTES: row_bytes_ff <= csr_wdata[bdsu_pkg::ROW_BYTES_W-1:0];
            bdsu_pkg::CSR_ROW_COUNT: row_count_ff <= csr_wdata[bdsu_pkg::ROW_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: decides which byte goes into the output register each cycle.
   bdsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: line store, counters, doubler and the output register.
   bdsu_dp #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .row_bytes      (row_bytes_ff),
      .row_count      (row_count_ff),
      .req_pixel_byte (req_pixel_byte),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_row_last   (rsp_row_last),
      .rsp_image_last (rsp_image_last)
   );

endmodule

### src/bdsu_ctrl.sv
// Sequencer of the bitmap 2x upscaler: steps through capture, low byte and row replay.
// Depends on bdsu_pkg for the state, command and status types.
module bdsu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bdsu_pkg::status_type  status,
   output bdsu_pkg::cmd_type     cmd
);

   bdsu_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdsu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         bdsu_pkg::ST_IDLE: begin
            req_ready = status.load_ok;
            if (req_valid && status.load_ok) begin
               cmd.take = 1'b1;
               state_in = bdsu_pkg::ST_LOW;
            end
         end
         bdsu_pkg::ST_LOW: begin
            if (status.load_ok) begin
               cmd.emit_low = 1'b1;
               state_in = status.row_end ? bdsu_pkg::ST_REPLAY_HI : bdsu_pkg::ST_IDLE;
            end
         end
         bdsu_pkg::ST_REPLAY_HI: begin
            if (status.load_ok) begin
               cmd.emit_rhi = 1'b1;
               state_in = bdsu_pkg::ST_REPLAY_LO;
            end
         end
         bdsu_pkg::ST_REPLAY_LO: begin
            if (status.load_ok) begin
               cmd.emit_rlo = 1'b1;
               state_in = status.replay_last ? bdsu_pkg::ST_IDLE : bdsu_pkg::ST_REPLAY_HI;
            end
         end
         default: begin
            state_in = bdsu_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### src/bdsu_dp.sv
// Datapath of the bitmap 2x upscaler: line store, position counters, doubler, output register.
// Depends on bdsu_pkg for command/status types, widths and double_bits.
module bdsu_dp #(
   parameter int unsigned MAX_ROW_BYTES = bdsu_pkg::MAX_ROW_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [bdsu_pkg::ROW_BYTES_W-1:0]    row_bytes,
   input  logic [bdsu_pkg::ROW_COUNT_W-1:0]    row_count,
   input  logic [7:0]                          req_pixel_byte,
   input  bdsu_pkg::cmd_type                   cmd,
   output bdsu_pkg::status_type                status,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_out_byte,
   output logic                                rsp_row_last,
   output logic                                rsp_image_last
);

   localparam int unsigned AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int unsigned CW = bdsu_pkg::ROW_BYTES_W;
   localparam int unsigned RW = bdsu_pkg::ROW_COUNT_W;

   logic [7:0]    store [MAX_ROW_BYTES];
   logic [7:0]    rd_ff;
   logic [7:0]    byte_ff;
   logic [CW-1:0] col_ff;
   logic [RW-1:0] row_ff;
   logic [AW-1:0] k_ff, k_in;
   logic          row_end_ff, image_end_ff;
   logic          rsp_valid_ff;
   logic [7:0]    out_byte_ff;
   logic          row_last_ff, image_last_ff;

   logic [CW-1:0] width;
   logic [RW-1:0] rows;
   logic          row_end_now, image_end_now;
   logic          replay_last;
   logic          load_ok;
   logic [15:0]   wide_new, wide_rd, wide_cur;

   // Clamp the working width to 1..MAX_ROW_BYTES; a zero row count acts as one.
   always_comb begin
      if (row_bytes == '0) begin
         width = CW'(1);
      end else if (row_bytes > CW'(MAX_ROW_BYTES)) begin
         width = CW'(MAX_ROW_BYTES);
      end else begin
         width = row_bytes;
      end
      rows = (row_count == '0) ? RW'(1) : row_count;
   end

   assign row_end_now   = ({1'b0, col_ff} + (CW+1)'(1)) >= {1'b0, width};
   assign image_end_now = row_end_now &&
                          (({1'b0, row_ff} + (RW+1)'(1)) >= {1'b0, rows});
   assign replay_last   = ((CW+1)'(k_ff) + (CW+1)'(1)) == {1'b0, width};
   assign load_ok       = !rsp_valid_ff || rsp_ready;

   assign wide_new = bdsu_pkg::double_bits(req_pixel_byte);
   assign wide_cur = bdsu_pkg::double_bits(byte_ff);
   assign wide_rd  = bdsu_pkg::double_bits(rd_ff);

   always_comb begin
      k_in = k_ff;
      if (cmd.emit_low) begin
         k_in = '0;
      end else if (cmd.emit_rlo) begin
         k_in = replay_last ? '0 : k_ff + AW'(1);
      end
   end

   // Line store: written on capture, read one entry ahead of the replay.
   always_ff @(posedge clock) begin
      if (cmd.take && (col_ff < CW'(MAX_ROW_BYTES))) begin
         store[col_ff[AW-1:0]] <= req_pixel_byte;
      end
      rd_ff <= store[k_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff <= k_in;
         if (cmd.emit_low) begin
            if (!row_end_ff) begin
               col_ff <= col_ff + CW'(1);
            end else begin
               col_ff <= '0;
               row_ff <= image_end_ff ? '0 : row_ff + RW'(1);
            end
         end
         if (cmd.take || cmd.emit_low || cmd.emit_rhi || cmd.emit_rlo) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         byte_ff       <= req_pixel_byte;
         row_end_ff    <= row_end_now;
         image_end_ff  <= image_end_now;
         out_byte_ff   <= wide_new[15:8];
         row_last_ff   <= 1'b0;
         image_last_ff <= 1'b0;
      end else if (cmd.emit_low) begin
         out_byte_ff   <= wide_cur[7:0];
         row_last_ff   <= row_end_ff;
         image_last_ff <= 1'b0;
      end else if (cmd.emit_rhi) begin
         out_byte_ff   <= wide_rd[15:8];
         row_last_ff   <= 1'b0;
         image_last_ff <= 1'b0;
      end else if (cmd.emit_rlo) begin
         out_byte_ff   <= wide_rd[7:0];
         row_last_ff   <= replay_last;
         image_last_ff <= replay_last && image_end_ff;
      end
   end

   assign status.load_ok     = load_ok;
   assign status.row_end     = row_end_ff;
   assign status.replay_last = replay_last;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_row_last   = row_last_ff;
   assign rsp_image_last = image_last_ff;

   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> rsp_valid_ff)
      else $error("captured request did not load the output register");

   a_image_ends_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && image_last_ff) |-> row_last_ff)
      else $error("image end marked off a row end");

   a_replay_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_rlo |-> ((CW+1)'(k_ff) < {1'b0, width}))
      else $error("replay index past the row width");

   a_replay_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_low |=> (k_ff == '0))
      else $error("replay index not rewound after the low byte");

endmodule

### verif/tb_top.sv
// Self-checking testbench for the one-bit-per-pixel bitmap 2x upscaler.
// Depends on bdsu_pkg and bitmap_double_size_upscaler; predicts every output byte
// from the accepted requests and compares the results in arrival order.
module tb_top;

   localparam int unsigned LINE_DEPTH   = bdsu_pkg::MAX_ROW_BYTES_DEF;
   localparam int unsigned SETTLE_TICKS = 4;     // output register plus sequencer slack
   localparam int unsigned RANDOM_ITEMS = 347;   // random requests after the directed part
   localparam int unsigned DRAIN_LIMIT  = 50000; // cycles allowed for the last bytes

   // One output byte of the upscaled stream.
   typedef struct packed {
      logic [7:0] pixels;
      logic       row_end;
      logic       image_end;
   } upscaled_beat_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [7:0]                      req_pixel_byte;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [7:0]                      rsp_out_byte;
   logic                            rsp_row_last;
   logic                            rsp_image_last;
   logic                            csr_we;
   logic [0:0]                      csr_index;
   logic [bdsu_pkg::CSR_DATA_W-1:0] csr_wdata;

   // Predictor state: line copy, position counters and register shadows.
   logic [7:0]                       line_copy [LINE_DEPTH];
   logic [bdsu_pkg::ROW_BYTES_W-1:0] col_pos;
   logic [bdsu_pkg::ROW_COUNT_W-1:0] row_pos;
   logic [bdsu_pkg::ROW_BYTES_W-1:0] cfg_row_bytes;
   logic [bdsu_pkg::ROW_COUNT_W-1:0] cfg_row_count;

   upscaled_beat_type upscaled_q [$];
   int unsigned       mismatch_count;
   int unsigned       requests_sent;
   bit                tail_quiet;     // no idling on either side
   int unsigned       hold_request;   // long receiver hold-off asked by a test

   bitmap_double_size_upscaler u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_byte (req_pixel_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_row_last   (rsp_row_last),
      .rsp_image_last (rsp_image_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #1 clock = ~clock;

   // Bail out if the run hangs.
   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

   // Spread every source pixel over two output pixels, bit by bit.
   function automatic logic [15:0] stretch_byte(input logic [7:0] b);
      logic [15:0] w;
      for (int i = 0; i < 8; i++) begin
         w[2*i]   = b[i];
         w[2*i+1] = b[i];
      end
      return w;
   endfunction

   function automatic int unsigned eff_row_bytes();
      int unsigned width;
      width = cfg_row_bytes;
      if (width < 1) width = 1;
      if (width > LINE_DEPTH) width = LINE_DEPTH;
      return width;
   endfunction

   function automatic int unsigned eff_row_count();
      int unsigned rows;
      rows = cfg_row_count;
      if (rows < 1) rows = 1;
      return rows;
   endfunction

   // Queue the output bytes that one accepted request causes.
   function automatic void upscale_pixel(input logic [7:0] b);
      int unsigned width;
      int unsigned rows;
      logic [15:0] w;
      logic        row_end;
      logic        image_end;
      logic        last;
      width = eff_row_bytes();
      rows  = eff_row_count();
      if (col_pos < LINE_DEPTH) line_copy[col_pos] = b;
      row_end   = (int'(col_pos) + 1 >= width);
      image_end = row_end && (int'(row_pos) + 1 >= rows);
      w = stretch_byte(b);
      upscaled_q.push_back('{w[15:8], 1'b0, 1'b0});
      upscaled_q.push_back('{w[7:0], row_end, 1'b0});
      if (!row_end) begin
         col_pos = col_pos + 1'b1;
         return;
      end
      // Replay the whole doubled row from the line copy.
      for (int k = 0; k < width; k++) begin
         w    = stretch_byte(line_copy[k]);
         last = (k + 1 == width);
         upscaled_q.push_back('{w[15:8], 1'b0, 1'b0});
         upscaled_q.push_back('{w[7:0], last, last && image_end});
      end
      col_pos = '0;
      row_pos = image_end ? '0 : row_pos + 1'b1;
   endfunction

   // Offer one request, optionally after a random gap, and hold it until taken.
   task automatic send_pixel(input logic [7:0] b);
      int unsigned gap;
      if (!tail_quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_pixel_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      upscale_pixel(b);
      requests_sent++;
   endtask

   // Drop valid and wait until every predicted byte has left the block.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (upscaled_q.size() > 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_reg(input bdsu_pkg::csr_index_type idx,
                            input logic [bdsu_pkg::CSR_DATA_W-1:0] data);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == bdsu_pkg::CSR_ROW_BYTES) cfg_row_bytes = data[bdsu_pkg::ROW_BYTES_W-1:0];
      else cfg_row_count = data[bdsu_pkg::ROW_COUNT_W-1:0];
   endtask

   task automatic send_random_pixels(input int unsigned n);
      for (int i = 0; i < n; i++) send_pixel(8'($urandom));
   endtask

   // Reset values: one byte per row, one row per image.
   task automatic test_default_registers();
      send_pixel(8'h00);
      send_pixel(8'hFF);
   endtask

   // Single-bit and alternating patterns across a 2x2 image.
   task automatic test_doubling_patterns();
      write_reg(bdsu_pkg::CSR_ROW_BYTES, 10'd2);
      write_reg(bdsu_pkg::CSR_ROW_COUNT, 10'd2);
      send_pixel(8'h80);
      send_pixel(8'h01);
      send_pixel(8'h55);
      send_pixel(8'hAA);
   endtask

   // Zero width and zero rows both act as one.
   task automatic test_zero_registers();
      write_reg(bdsu_pkg::CSR_ROW_BYTES, 10'd0);
      write_reg(bdsu_pkg::CSR_ROW_COUNT, 10'd0);
      send_pixel(8'h3C);
      send_pixel(8'hC3);
   endtask

   // A width past the line store clamps to the full store.
   task automatic test_width_clamp();
      write_reg(bdsu_pkg::CSR_ROW_BYTES, 10'd31);
      write_reg(bdsu_pkg::CSR_ROW_COUNT, 10'd1);
      send_random_pixels(LINE_DEPTH);
   endtask

   // Change registers mid-image: counters stay, and positions past the new
   // limits end the row and the image on the next request.
   task automatic test_mid_image_change();
      write_reg(bdsu_pkg::CSR_ROW_BYTES, 10'd1);
      write_reg(bdsu_pkg::CSR_ROW_COUNT, 10'd1023);
      send_pixel(8'h0F);
      send_pixel(8'hF0);
      write_reg(bdsu_pkg::CSR_ROW_BYTES, 10'd4);
      send_pixel(8'h81);
      send_pixel(8'h7E);
      write_reg(bdsu_pkg::CSR_ROW_BYTES, 10'd2);
      write_reg(bdsu_pkg::CSR_ROW_COUNT, 10'd2);
      send_pixel(8'h99);
   endtask

   // Hold the receiver off for a long stretch so the block fills and stalls requests.
   task automatic test_backpressure();
      write_reg(bdsu_pkg::CSR_ROW_BYTES, 10'd4);
      write_reg(bdsu_pkg::CSR_ROW_COUNT, 10'd3);
      hold_request = 300;
      send_random_pixels(12);
   endtask

   // Random geometries; mostly whole images, some cut short so the next
   // register write lands mid-image.
   task automatic test_random_images();
      int unsigned target;
      int unsigned count;
      target = requests_sent + RANDOM_ITEMS;
      while (requests_sent < target) begin
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0: write_reg(bdsu_pkg::CSR_ROW_BYTES, 10'd16);
               1: write_reg(bdsu_pkg::CSR_ROW_BYTES, 10'($urandom));
               default: write_reg(bdsu_pkg::CSR_ROW_BYTES, 10'($urandom_range(1, 4)));
            endcase
         end
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0: write_reg(bdsu_pkg::CSR_ROW_COUNT, 10'($urandom));
               1: write_reg(bdsu_pkg::CSR_ROW_COUNT, 10'd1);
               default: write_reg(bdsu_pkg::CSR_ROW_COUNT, 10'($urandom_range(1, 4)));
            endcase
         end
         if ($urandom_range(0, 4) == 0) count = $urandom_range(1, 20);
         else count = eff_row_bytes() * eff_row_count();
         if (count > 48) count = 48;
         if (count > target - requests_sent) count = target - requests_sent;
         send_random_pixels(count);
      end
   endtask

   // Back-to-back traffic at full rate on both sides.
   task automatic test_quiet_tail();
      wait_idle();
      tail_quiet = 1'b1;
      write_reg(bdsu_pkg::CSR_ROW_BYTES, 10'd3);
      write_reg(bdsu_pkg::CSR_ROW_COUNT, 10'd2);
      send_random_pixels(6);
      write_reg(bdsu_pkg::CSR_ROW_BYTES, 10'd16);
      write_reg(bdsu_pkg::CSR_ROW_COUNT, 10'd1);
      send_random_pixels(16);
   endtask

   // Receiver: check each accepted byte, then pick next cycle's ready.
   initial begin
      upscaled_beat_type want;
      int unsigned       stall_left;
      int unsigned       hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (upscaled_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response: expected none, actual byte %02h",
                        $time, rsp_out_byte);
            end else begin
               want = upscaled_q.pop_front();
               if (rsp_out_byte !== want.pixels) begin
                  mismatch_count++;
                  $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                           $time, want.pixels, rsp_out_byte);
               end
               if (rsp_row_last !== want.row_end) begin
                  mismatch_count++;
                  $display("%0t: row_last mismatch: expected %0b, actual %0b",
                           $time, want.row_end, rsp_row_last);
               end
               if (rsp_image_last !== want.image_end) begin
                  mismatch_count++;
                  $display("%0t: image_last mismatch: expected %0b, actual %0b",
                           $time, want.image_end, rsp_image_last);
               end
            end
         end
         // Pick up a long hold-off request, otherwise stall in short random bursts.
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!tail_quiet && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stimulus: reset once, then run each test in turn.
   initial begin
      int unsigned drain_ticks;
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_pixel_byte = '0;
      csr_we         = 1'b0;
      csr_index      = bdsu_pkg::CSR_ROW_BYTES;
      csr_wdata      = '0;
      tail_quiet     = 1'b0;
      hold_request   = 0;
      mismatch_count = 0;
      requests_sent  = 0;
      foreach (line_copy[i]) line_copy[i] = '0;
      col_pos       = '0;
      row_pos       = '0;
      cfg_row_bytes = bdsu_pkg::ROW_BYTES_RST;
      cfg_row_count = bdsu_pkg::ROW_COUNT_RST;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_default_registers();
      test_doubling_patterns();
      test_zero_registers();
      test_width_clamp();
      test_mid_image_change();
      test_backpressure();
      test_random_images();
      test_quiet_tail();

      // Drain: wait for the last predicted bytes, with a limit.
      req_valid <= 1'b0;
      drain_ticks = 0;
      while (upscaled_q.size() > 0 && drain_ticks < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_ticks++;
      end
      if (upscaled_q.size() > 0) begin
         mismatch_count++;
         $display("%0t: missing responses: expected %0d more, actual 0",
                  $time, upscaled_q.size());
      end
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
